FILE: sv/xhd_pkg.sv
// shared constants, types and state codes of the xpress huffman decompressor
`default_nettype none
package xhd_pkg;

  localparam int MAX_CHUNK    = 16384;
  localparam int CODE_BITS    = 15;
  localparam int SYMBOL_COUNT = 512;

  localparam int ADDR_W    = $clog2(MAX_CHUNK);
  localparam int CNT_W     = $clog2(MAX_CHUNK + 1);
  localparam int TBL_SIZE  = 1 << CODE_BITS;
  localparam int ENT_W     = CODE_BITS + 1;
  localparam int SYM_W     = $clog2(SYMBOL_COUNT);
  localparam int LEN_W     = 4;
  localparam int TE_W      = LEN_W + SYM_W;
  localparam int LEN_BYTES = SYMBOL_COUNT / 2;
  localparam int LB_W      = $clog2(LEN_BYTES);
  localparam int PLAIN_W   = 15;
  localparam int MLEN_W    = 17;
  localparam int OFF_W     = 16;
  localparam int WIN_W     = 32;

  localparam int HEADER_BYTES = 260;
  localparam int PLAIN_RESET  = 4096;
  localparam int LIT_SYMS     = 256;
  localparam int ESC_LEN      = 15;
  localparam int WIDE_ESC     = 255;
  localparam int MIN_WIDE_LEN = 15;
  localparam int MIN_MATCH    = 3;

  typedef enum logic {
    CMD_LOAD,
    CMD_PULL
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_CORRUPT = 2'd1,
    STAT_EMPTY   = 2'd2
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_BLD_ADDR,
    ST_BLD_NIB,
    ST_BLD_FILL,
    ST_BLD_END,
    ST_PRM_ADDR,
    ST_PRM_CAP,
    ST_PULL,
    ST_DEC_LOOK,
    ST_DEC_SYM,
    ST_CON_CHK,
    ST_CON_LO,
    ST_CON_HI,
    ST_DEC_AFTER,
    ST_EXT_CAP,
    ST_EXTW_LO,
    ST_EXTW_HI,
    ST_OFF,
    ST_RANGE,
    ST_CPY_RD,
    ST_CPY_DATA,
    ST_EMIT
  } eng_state_t;

endpackage
`default_nettype wire

FILE: sv/xhd_ram.sv
// generic single-port-write ram with registered read
`default_nettype none
module xhd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: sv/xhd_front.sv
// input front: classifies transfers, drops late loads, two-entry command queue
`default_nettype none
module xhd_front
  import xhd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output      logic       in_stall,
  input  wire logic       in_mode,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_last,
  output      qhead_t     q_head,
  input  wire logic       q_pop
);

  cmd_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       seen_last_r, seen_last_nxt;
  logic       acc, push, pop;
  cmd_t       cmd_in;

  assign in_stall = (cnt_r == 2'd2);
  assign acc      = in_valid && !in_stall;
  assign push     = acc && (in_mode || !seen_last_r);
  assign pop      = q_pop && (cnt_r != 2'd0);

  always_comb begin
    cmd_in.kind = in_mode ? CMD_PULL : CMD_LOAD;
    cmd_in.data = in_byte;
    cmd_in.last = in_last;
  end

  always_comb begin
    wp_nxt        = push ? ~wp_r : wp_r;
    rp_nxt        = pop ? ~rp_r : rp_r;
    cnt_nxt       = cnt_r + {1'b0, push} - {1'b0, pop};
    seen_last_nxt = seen_last_r || (acc && !in_mode && in_last);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= 1'b0;
      rp_r        <= 1'b0;
      cnt_r       <= 2'd0;
      seen_last_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      cnt_r       <= cnt_nxt;
      seen_last_r <= seen_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= cmd_in;
    end
  end

  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.cmd   = slot_r[rp_r];

endmodule
`default_nettype wire

FILE: sv/xhd_engine.sv
// back end: store loads, table build, bit reader, match copy and result register
`default_nettype none
module xhd_engine
  import xhd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [PLAIN_W-1:0] cfg_plain_size,
  input  wire qhead_t             q_head,
  output      logic               q_pop,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [7:0]         out_byte,
  output      logic               out_last,
  output      logic [1:0]         out_status
);

  eng_state_t state_r, state_nxt;

  logic [PLAIN_W-1:0]   plain_size_r, plain_size_nxt;
  logic [CNT_W-1:0]     loaded_r, loaded_nxt;
  logic                 load_done_r, load_done_nxt;
  logic                 corrupt_r, corrupt_nxt;
  logic [WIN_W-1:0]     win_r, win_nxt;
  logic signed [5:0]    spare_r, spare_nxt;
  logic [CNT_W-1:0]     rdp_r, rdp_nxt;
  logic [CNT_W-1:0]     prod_r, prod_nxt;
  logic [CNT_W-1:0]     copy_left_r, copy_left_nxt;
  logic [CNT_W-1:0]     dist_r, dist_nxt;
  logic [SYM_W-1:0]     sym_r, sym_nxt;
  logic [LEN_W-1:0]     cons_n_r, cons_n_nxt;
  logic                 cons_off_r, cons_off_nxt;
  logic [7:0]           lo_r, lo_nxt;
  logic [MLEN_W-1:0]    mlen_r, mlen_nxt;
  logic [OFF_W-1:0]     off_r, off_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [LB_W-1:0]      lb_r, lb_nxt;
  logic                 half_r, half_nxt;
  logic [ENT_W-1:0]     entry_r, entry_nxt;
  logic [CODE_BITS-1:0] rep_r, rep_nxt;
  logic [1:0]           pi_r, pi_nxt;
  logic [7:0]           res_byte_r, res_byte_nxt;
  status_t              res_status_r, res_status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_last_r, out_last_nxt;
  status_t              out_status_r, out_status_nxt;

  logic              st_we, st_re;
  logic [ADDR_W-1:0] st_waddr, st_raddr;
  logic [7:0]        st_wdata, st_rdata;
  logic              tb_we, tb_re;
  logic [CODE_BITS-1:0] tb_waddr, tb_raddr;
  logic [TE_W-1:0]   tb_wdata, tb_rdata;
  logic              hs_we, hs_re;
  logic [ADDR_W-1:0] hs_waddr, hs_raddr;
  logic [7:0]        hs_wdata, hs_rdata;

  xhd_ram #(.WIDTH(8), .DEPTH(MAX_CHUNK)) u_store (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .re(st_re), .raddr(st_raddr), .rdata(st_rdata)
  );

  xhd_ram #(.WIDTH(TE_W), .DEPTH(TBL_SIZE)) u_table (
    .clk(clk), .we(tb_we), .waddr(tb_waddr), .wdata(tb_wdata),
    .re(tb_re), .raddr(tb_raddr), .rdata(tb_rdata)
  );

  xhd_ram #(.WIDTH(8), .DEPTH(MAX_CHUNK)) u_history (
    .clk(clk), .we(hs_we), .waddr(hs_waddr), .wdata(hs_wdata),
    .re(hs_re), .raddr(hs_raddr), .rdata(hs_rdata)
  );

  // shared terms
  logic [31:0]          plain32;
  logic [CNT_W-1:0]     limit;
  logic                 out_free;
  logic                 is_load_last;
  logic [CNT_W-1:0]     count_after;
  logic [LEN_W-1:0]     rd_nib;
  logic [CODE_BITS-1:0] rep_val;
  logic                 fit_bad;
  logic                 adv_half;
  logic [LB_W-1:0]      adv_lb;
  logic [LEN_W-1:0]     adv_len;
  eng_state_t           adv_state;
  logic signed [5:0]    spare_dec;
  logic                 cons_need;
  logic                 word_short;
  logic [15:0]          word;
  logic signed [5:0]    neg_spare;
  logic [LEN_W-1:0]     obits;
  logic [OFF_W-1:0]     top_bits;
  logic [OFF_W-1:0]     off_val;
  logic                 range_bad;
  logic                 emit_last;
  logic [LEN_W-1:0]     clen;
  logic                 pull_empty;

  assign plain32  = 32'(plain_size_r);
  assign limit    = (plain32 > 32'(MAX_CHUNK)) ? CNT_W'(MAX_CHUNK) : CNT_W'(plain32);
  assign out_free = !out_valid_r || !out_stall;

  assign is_load_last = q_head.cmd.last && !load_done_r;
  assign count_after  = (loaded_r < CNT_W'(MAX_CHUNK)) ? loaded_r + CNT_W'(1) : loaded_r;

  assign rd_nib  = half_r ? st_rdata[7:4] : st_rdata[3:0];
  assign rep_val = CODE_BITS'(1) << (LEN_W'(CODE_BITS) - len_r);
  assign fit_bad = ({1'b0, entry_r} + (ENT_W+1)'(rep_val)) > (ENT_W+1)'(TBL_SIZE);

  always_comb begin
    adv_half  = ~half_r;
    adv_lb    = lb_r;
    adv_len   = len_r;
    adv_state = ST_BLD_NIB;
    if (half_r) begin
      adv_state = ST_BLD_ADDR;
      adv_lb    = lb_r + LB_W'(1);
      if (lb_r == LB_W'(LEN_BYTES - 1)) begin
        adv_len = len_r + LEN_W'(1);
        if (len_r == LEN_W'(CODE_BITS)) begin
          adv_state = ST_BLD_END;
        end
      end
    end
  end

  assign spare_dec  = spare_r - $signed({2'b00, cons_n_r});
  assign cons_need  = spare_dec[5];
  assign word_short = ({1'b0, rdp_r} + (CNT_W+1)'(2)) > {1'b0, loaded_r};
  assign word       = {st_rdata, lo_r};
  assign neg_spare  = -spare_r;

  assign obits    = sym_r[7:4];
  assign top_bits = win_r[WIN_W-1 -: OFF_W] >> (5'd16 - {1'b0, obits});
  assign off_val  = (OFF_W'(1) << obits) + ((obits != '0) ? top_bits : '0);

  assign range_bad = (18'(off_r) > 18'(prod_r)) || (mlen_r > MLEN_W'(limit - prod_r));
  assign emit_last = ({1'b0, prod_r} + (CNT_W+1)'(1)) == {1'b0, limit};
  assign clen      = tb_rdata[TE_W-1 -: LEN_W];
  assign pull_empty = !load_done_r || (prod_r >= limit);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (q_head.valid) begin
          if (q_head.cmd.kind == CMD_PULL) begin
            state_nxt = ST_PULL;
          end else if (is_load_last && count_after >= CNT_W'(HEADER_BYTES)) begin
            state_nxt = ST_BLD_ADDR;
          end
        end
      end
      ST_BLD_ADDR: state_nxt = ST_BLD_NIB;
      ST_BLD_NIB: begin
        if (rd_nib == len_r) begin
          state_nxt = fit_bad ? ST_IDLE : ST_BLD_FILL;
        end else begin
          state_nxt = adv_state;
        end
      end
      ST_BLD_FILL: begin
        if (rep_r == CODE_BITS'(1)) begin
          state_nxt = adv_state;
        end
      end
      ST_BLD_END:  state_nxt = (entry_r == ENT_W'(TBL_SIZE)) ? ST_PRM_ADDR : ST_IDLE;
      ST_PRM_ADDR: state_nxt = ST_PRM_CAP;
      ST_PRM_CAP:  state_nxt = (pi_r == 2'd3) ? ST_IDLE : ST_PRM_ADDR;
      ST_PULL: begin
        if (pull_empty || corrupt_r) begin
          state_nxt = ST_EMIT;
        end else if (copy_left_r == '0) begin
          state_nxt = ST_DEC_LOOK;
        end else begin
          state_nxt = ST_CPY_RD;
        end
      end
      ST_DEC_LOOK: state_nxt = ST_DEC_SYM;
      ST_DEC_SYM:  state_nxt = (clen == '0) ? ST_EMIT : ST_CON_CHK;
      ST_CON_CHK: begin
        if (cons_need) begin
          state_nxt = word_short ? ST_EMIT : ST_CON_LO;
        end else begin
          state_nxt = cons_off_r ? ST_RANGE : ST_DEC_AFTER;
        end
      end
      ST_CON_LO: state_nxt = ST_CON_HI;
      ST_CON_HI: state_nxt = cons_off_r ? ST_RANGE : ST_DEC_AFTER;
      ST_DEC_AFTER: begin
        if (sym_r < SYM_W'(LIT_SYMS)) begin
          state_nxt = ST_EMIT;
        end else if (sym_r[3:0] == 4'(ESC_LEN)) begin
          state_nxt = (rdp_r >= loaded_r) ? ST_EMIT : ST_EXT_CAP;
        end else begin
          state_nxt = ST_OFF;
        end
      end
      ST_EXT_CAP: begin
        if (st_rdata != 8'(WIDE_ESC)) begin
          state_nxt = ST_OFF;
        end else begin
          state_nxt = word_short ? ST_EMIT : ST_EXTW_LO;
        end
      end
      ST_EXTW_LO: state_nxt = ST_EXTW_HI;
      ST_EXTW_HI: state_nxt = (word < 16'(MIN_WIDE_LEN)) ? ST_EMIT : ST_OFF;
      ST_OFF:     state_nxt = (obits != '0) ? ST_CON_CHK : ST_RANGE;
      ST_RANGE:   state_nxt = range_bad ? ST_EMIT : ST_CPY_RD;
      ST_CPY_RD:  state_nxt = ST_CPY_DATA;
      ST_CPY_DATA: state_nxt = ST_EMIT;
      ST_EMIT:    state_nxt = out_free ? ST_IDLE : ST_EMIT;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    plain_size_nxt = cfg_wr_en ? cfg_plain_size : plain_size_r;
    loaded_nxt     = loaded_r;
    load_done_nxt  = load_done_r;
    corrupt_nxt    = corrupt_r;
    win_nxt        = win_r;
    spare_nxt      = spare_r;
    rdp_nxt        = rdp_r;
    prod_nxt       = prod_r;
    copy_left_nxt  = copy_left_r;
    dist_nxt       = dist_r;
    sym_nxt        = sym_r;
    cons_n_nxt     = cons_n_r;
    cons_off_nxt   = cons_off_r;
    lo_nxt         = lo_r;
    mlen_nxt       = mlen_r;
    off_nxt        = off_r;
    len_nxt        = len_r;
    lb_nxt         = lb_r;
    half_nxt       = half_r;
    entry_nxt      = entry_r;
    rep_nxt        = rep_r;
    pi_nxt         = pi_r;
    res_byte_nxt   = res_byte_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_byte_nxt   = out_byte_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    q_pop    = 1'b0;
    st_we    = 1'b0;
    st_waddr = ADDR_W'(loaded_r);
    st_wdata = q_head.cmd.data;
    st_re    = 1'b0;
    st_raddr = ADDR_W'(rdp_r);
    tb_we    = 1'b0;
    tb_waddr = entry_r[CODE_BITS-1:0];
    tb_wdata = {len_r, lb_r, half_r};
    tb_re    = 1'b0;
    tb_raddr = win_r[WIN_W-1 -: CODE_BITS];
    hs_we    = 1'b0;
    hs_waddr = ADDR_W'(prod_r);
    hs_wdata = res_byte_r;
    hs_re    = 1'b0;
    hs_raddr = ADDR_W'(prod_r - dist_r);

    unique case (state_r)
      ST_IDLE: begin
        if (q_head.valid) begin
          q_pop = 1'b1;
          if (q_head.cmd.kind == CMD_LOAD && !load_done_r) begin
            if (loaded_r >= CNT_W'(MAX_CHUNK)) begin
              corrupt_nxt = 1'b1;
            end else begin
              st_we      = 1'b1;
              loaded_nxt = loaded_r + CNT_W'(1);
            end
            if (is_load_last) begin
              load_done_nxt = 1'b1;
              len_nxt       = LEN_W'(1);
              lb_nxt        = '0;
              half_nxt      = 1'b0;
              entry_nxt     = '0;
              if (count_after < CNT_W'(HEADER_BYTES)) begin
                corrupt_nxt = 1'b1;
              end
            end
          end
        end
      end
      ST_BLD_ADDR: begin
        st_re    = 1'b1;
        st_raddr = ADDR_W'(lb_r);
      end
      ST_BLD_NIB: begin
        if (rd_nib == len_r) begin
          if (fit_bad) begin
            corrupt_nxt = 1'b1;
          end else begin
            rep_nxt = rep_val;
          end
        end else begin
          half_nxt = adv_half;
          lb_nxt   = adv_lb;
          len_nxt  = adv_len;
        end
      end
      ST_BLD_FILL: begin
        tb_we     = 1'b1;
        entry_nxt = entry_r + ENT_W'(1);
        rep_nxt   = rep_r - CODE_BITS'(1);
        if (rep_r == CODE_BITS'(1)) begin
          half_nxt = adv_half;
          lb_nxt   = adv_lb;
          len_nxt  = adv_len;
        end
      end
      ST_BLD_END: begin
        pi_nxt = '0;
        if (entry_r != ENT_W'(TBL_SIZE)) begin
          corrupt_nxt = 1'b1;
        end
      end
      ST_PRM_ADDR: begin
        st_re    = 1'b1;
        st_raddr = ADDR_W'(LEN_BYTES) + ADDR_W'(pi_r);
      end
      ST_PRM_CAP: begin
        case (pi_r)
          2'd0:    win_nxt[23:16] = st_rdata;
          2'd1:    win_nxt[31:24] = st_rdata;
          2'd2:    win_nxt[7:0]   = st_rdata;
          default: win_nxt[15:8]  = st_rdata;
        endcase
        pi_nxt    = pi_r + 2'd1;
        spare_nxt = 6'sd16;
        rdp_nxt   = CNT_W'(HEADER_BYTES);
      end
      ST_PULL: begin
        res_byte_nxt = '0;
        if (pull_empty) begin
          res_status_nxt = STAT_EMPTY;
        end else if (corrupt_r) begin
          res_status_nxt = STAT_CORRUPT;
        end else begin
          res_status_nxt = STAT_OK;
        end
      end
      ST_DEC_LOOK: begin
        tb_re = 1'b1;
      end
      ST_DEC_SYM: begin
        sym_nxt      = tb_rdata[SYM_W-1:0];
        cons_n_nxt   = clen;
        cons_off_nxt = 1'b0;
        if (clen == '0) begin
          corrupt_nxt    = 1'b1;
          res_status_nxt = STAT_CORRUPT;
        end
      end
      ST_CON_CHK: begin
        win_nxt   = win_r << cons_n_r;
        spare_nxt = spare_dec;
        if (cons_need) begin
          if (word_short) begin
            corrupt_nxt    = 1'b1;
            res_status_nxt = STAT_CORRUPT;
          end else begin
            st_re = 1'b1;
          end
        end
      end
      ST_CON_LO: begin
        lo_nxt   = st_rdata;
        st_re    = 1'b1;
        st_raddr = ADDR_W'(rdp_r + CNT_W'(1));
      end
      ST_CON_HI: begin
        win_nxt   = win_r | (WIN_W'(word) << neg_spare[3:0]);
        rdp_nxt   = rdp_r + CNT_W'(2);
        spare_nxt = spare_r + 6'sd16;
      end
      ST_DEC_AFTER: begin
        if (sym_r < SYM_W'(LIT_SYMS)) begin
          res_byte_nxt   = sym_r[7:0];
          res_status_nxt = STAT_OK;
        end else if (sym_r[3:0] == 4'(ESC_LEN)) begin
          if (rdp_r >= loaded_r) begin
            corrupt_nxt    = 1'b1;
            res_status_nxt = STAT_CORRUPT;
          end else begin
            st_re   = 1'b1;
            rdp_nxt = rdp_r + CNT_W'(1);
          end
        end else begin
          mlen_nxt = MLEN_W'(sym_r[3:0]) + MLEN_W'(MIN_MATCH);
        end
      end
      ST_EXT_CAP: begin
        if (st_rdata != 8'(WIDE_ESC)) begin
          mlen_nxt = MLEN_W'(st_rdata) + MLEN_W'(ESC_LEN + MIN_MATCH);
        end else if (word_short) begin
          corrupt_nxt    = 1'b1;
          res_status_nxt = STAT_CORRUPT;
        end else begin
          st_re = 1'b1;
        end
      end
      ST_EXTW_LO: begin
        lo_nxt   = st_rdata;
        st_re    = 1'b1;
        st_raddr = ADDR_W'(rdp_r + CNT_W'(1));
      end
      ST_EXTW_HI: begin
        rdp_nxt  = rdp_r + CNT_W'(2);
        mlen_nxt = MLEN_W'(word) + MLEN_W'(MIN_MATCH);
        if (word < 16'(MIN_WIDE_LEN)) begin
          corrupt_nxt    = 1'b1;
          res_status_nxt = STAT_CORRUPT;
        end
      end
      ST_OFF: begin
        off_nxt      = off_val;
        cons_n_nxt   = obits;
        cons_off_nxt = 1'b1;
      end
      ST_RANGE: begin
        if (range_bad) begin
          corrupt_nxt    = 1'b1;
          res_status_nxt = STAT_CORRUPT;
        end else begin
          copy_left_nxt = CNT_W'(mlen_r);
          dist_nxt      = CNT_W'(off_r);
        end
      end
      ST_CPY_RD: begin
        hs_re = 1'b1;
      end
      ST_CPY_DATA: begin
        res_byte_nxt   = hs_rdata;
        res_status_nxt = STAT_OK;
        copy_left_nxt  = copy_left_r - CNT_W'(1);
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          if (res_status_r == STAT_OK) begin
            out_byte_nxt = res_byte_r;
            out_last_nxt = emit_last;
            hs_we        = 1'b1;
            prod_nxt     = prod_r + CNT_W'(1);
          end else begin
            out_byte_nxt = '0;
            out_last_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      plain_size_r <= PLAIN_W'(PLAIN_RESET);
      loaded_r     <= '0;
      load_done_r  <= 1'b0;
      corrupt_r    <= 1'b0;
      win_r        <= '0;
      spare_r      <= 6'sd16;
      rdp_r        <= CNT_W'(HEADER_BYTES);
      prod_r       <= '0;
      copy_left_r  <= '0;
      dist_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      plain_size_r <= plain_size_nxt;
      loaded_r     <= loaded_nxt;
      load_done_r  <= load_done_nxt;
      corrupt_r    <= corrupt_nxt;
      win_r        <= win_nxt;
      spare_r      <= spare_nxt;
      rdp_r        <= rdp_nxt;
      prod_r       <= prod_nxt;
      copy_left_r  <= copy_left_nxt;
      dist_r       <= dist_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r        <= sym_nxt;
    cons_n_r     <= cons_n_nxt;
    cons_off_r   <= cons_off_nxt;
    lo_r         <= lo_nxt;
    mlen_r       <= mlen_nxt;
    off_r        <= off_nxt;
    len_r        <= len_nxt;
    lb_r         <= lb_nxt;
    half_r       <= half_nxt;
    entry_r      <= entry_nxt;
    rep_r        <= rep_nxt;
    pi_r         <= pi_nxt;
    res_byte_r   <= res_byte_nxt;
    res_status_r <= res_status_nxt;
    out_byte_r   <= out_byte_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

endmodule
`default_nettype wire

FILE: sv/xpress_huffman_decompressor_top.sv
// top level of the xpress huffman chunk decompressor
// usage:
//   input channel (in_valid/in_stall): in_mode 0 loads one compressed byte,
//   in_last marks the final one; in_mode 1 pulls the next plain byte.
//   result channel (out_valid/out_stall): one transfer per pull carrying
//   out_byte, out_last and out_status (0 ok, 1 corrupt, 2 nothing available).
//   cfg_wr_en/cfg_plain_size set the plain size; the user must write it only
//   while the block is idle, as the block itself does not enforce this.
//   a two-entry command queue takes one input transfer per cycle while it
//   has room; loads retire one per cycle in the back end while it is idle.
//   after the last load the back end builds the decode table: it scans the
//   code lengths from 1 to 15 and writes all 32768 table entries, then primes
//   the bit window from four header bytes; pulls wait in the queue meanwhile.
//   a literal needs a table read, plus a two-byte store read when the bit window
//   refills; a match also decodes its length and offset bits and reads each byte
//   from the history ram; status-only answers skip the decoding steps.
// reset: rst_n synchronous active low, clears counters, flags and queue.
// a stalled result holds in the output register; the back end waits and
//   the queue then fills and raises in_stall.
`default_nettype none
module xpress_huffman_decompressor_top
  import xhd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire logic               in_mode,
  input  wire logic [7:0]         in_byte,
  input  wire logic               in_last,
  output      logic               out_valid,
  input  wire logic               out_stall,
  output      logic [7:0]         out_byte,
  output      logic               out_last,
  output      logic [1:0]         out_status,
  input  wire logic               cfg_wr_en,
  input  wire logic [PLAIN_W-1:0] cfg_plain_size
);

  qhead_t q_head;
  logic   q_pop;

  xhd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .q_head   (q_head),
    .q_pop    (q_pop)
  );

  xhd_engine u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_plain_size (cfg_plain_size),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last       (out_last),
    .out_status     (out_status)
  );

endmodule
`default_nettype wire
